// ----- src/tpfpe_pkg.sv -----
package tpfpe_pkg;

  // Fixed frame layout and field widths.
  localparam int LINK_HEADER_BYTES = 14;
  localparam int PORT_REGS         = 4;
  localparam int PORT_ENTRIES_DEF  = 4;
  localparam int MIN_TCP_WORDS     = 5;

  // Result queue depth; two slots must be free before a byte is taken.
  localparam int RESULT_DEPTH = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TDATA_OUT_W = 48;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENTRY_COUNT = 3'd0,
    REG_PORT_0      = 3'd1,
    REG_PORT_1      = 3'd2,
    REG_PORT_2      = 3'd3,
    REG_PORT_3      = 3'd4,
    REG_DIR_MASK    = 3'd5
  } reg_index_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [2:0]                 entry_count;
    logic [PORT_REGS-1:0][15:0] ports;
    logic [PORT_REGS-1:0]       dir_mask;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        verdict;
    logic [15:0] matched_port;
    logic        matched_from_destination;
    logic [15:0] payload_length;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] port;
    logic        from_destination;
  } match_t;

endpackage

// ----- src/tpfpe_port_match.sv -----
module tpfpe_port_match
  import tpfpe_pkg::*;
#(
  parameter int PORT_ENTRIES = PORT_ENTRIES_DEF
) (
  input  cfg_t        cfg,
  input  logic [15:0] source_port,
  input  logic [15:0] destination_port,
  output match_t      match
);

  localparam int ACTIVE = (PORT_ENTRIES < PORT_REGS) ? PORT_ENTRIES : PORT_REGS;

  // Entries are scanned in order, so the highest matching entry wins.
  always_comb begin
    match = '0;
    for (int i = 0; i < ACTIVE; i++) begin
      if (32'(cfg.entry_count) > i) begin
        if ((cfg.dir_mask[i] ? destination_port : source_port) == cfg.ports[i]) begin
          match.hit              = 1'b1;
          match.port             = cfg.ports[i];
          match.from_destination = cfg.dir_mask[i];
        end
      end
    end
  end

endmodule

// ----- src/tpfpe_parser.sv -----
module tpfpe_parser
  import tpfpe_pkg::*;
#(
  parameter int PORT_ENTRIES = PORT_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  logic [15:0] byte_position;
  logic [3:0]  ip_header_words;
  logic [3:0]  tcp_header_words;
  logic [15:0] ip_total_length;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic        match_found;
  logic [15:0] match_port;
  logic        match_direction;
  logic [15:0] payload_count;
  logic        count_overflow;

  logic [3:0]  ip_header_words_next;
  logic [3:0]  tcp_header_words_next;
  logic [15:0] ip_total_length_next;
  logic [15:0] source_port_next;
  logic [15:0] destination_port_next;
  logic        match_found_next;
  logic [15:0] match_port_next;
  logic        match_direction_next;
  logic [15:0] payload_count_next;
  logic        count_overflow_next;
  logic [15:0] byte_position_next;

  logic        active;
  logic [6:0]  tcp_start;
  logic [7:0]  pay_start;
  logic        in_tcp;
  logic [15:0] tcp_offset;
  logic        do_match;
  logic        in_payload;
  logic        emit_payload;
  logic [6:0]  header_bytes;
  logic        frame_ok;
  match_t      match;
  result_t     pay_res;
  result_t     verd_res;

  tpfpe_port_match #(
    .PORT_ENTRIES(PORT_ENTRIES)
  ) u_match (
    .cfg             (cfg),
    .source_port     (source_port_next),
    .destination_port(destination_port_next),
    .match           (match)
  );

  always_comb begin
    count_overflow_next = count_overflow | (byte_position == 16'hFFFF);
    active              = !count_overflow_next;

    ip_header_words_next = ip_header_words;
    ip_total_length_next = ip_total_length;
    if (active && byte_position == 16'(LINK_HEADER_BYTES)) begin
      ip_header_words_next = data_byte[3:0];
    end
    if (active && byte_position == 16'(LINK_HEADER_BYTES + 2)) begin
      ip_total_length_next = {data_byte, ip_total_length[7:0]};
    end
    if (active && byte_position == 16'(LINK_HEADER_BYTES + 3)) begin
      ip_total_length_next = {ip_total_length[15:8], data_byte};
    end

    tcp_start  = 7'(LINK_HEADER_BYTES) + {1'b0, ip_header_words_next, 2'b00};
    in_tcp     = active && (byte_position >= 16'(tcp_start));
    tcp_offset = byte_position - 16'(tcp_start);

    source_port_next      = source_port;
    destination_port_next = destination_port;
    tcp_header_words_next = tcp_header_words;
    do_match              = 1'b0;
    if (in_tcp) begin
      case (tcp_offset)
        16'd0:   source_port_next      = {data_byte, source_port[7:0]};
        16'd1:   source_port_next      = {source_port[15:8], data_byte};
        16'd2:   destination_port_next = {data_byte, destination_port[7:0]};
        16'd3: begin
          destination_port_next = {destination_port[15:8], data_byte};
          do_match              = 1'b1;
        end
        16'd12:  tcp_header_words_next = data_byte[7:4];
        default: ;
      endcase
    end

    match_found_next     = match_found;
    match_port_next      = match_port;
    match_direction_next = match_direction;
    if (do_match && match.hit) begin
      match_found_next     = 1'b1;
      match_port_next      = match.port;
      match_direction_next = match.from_destination;
    end

    pay_start  = 8'(tcp_start) + {2'b00, tcp_header_words_next, 2'b00};
    in_payload = active && (tcp_header_words_next >= 4'(MIN_TCP_WORDS))
                 && (byte_position >= 16'(pay_start));
    payload_count_next = payload_count;
    if (in_payload && payload_count != 16'hFFFF) begin
      payload_count_next = payload_count + 16'd1;
    end
    emit_payload = in_payload && match_found_next;

    byte_position_next = active ? byte_position + 16'd1 : byte_position;

    header_bytes = {1'b0, ip_header_words_next, 2'b00} + {1'b0, tcp_header_words_next, 2'b00};
    frame_ok = match_found_next && !count_overflow_next
               && (tcp_header_words_next >= 4'(MIN_TCP_WORDS))
               && (payload_count_next != 16'd0)
               && (ip_total_length_next >= 16'(header_bytes))
               && ((ip_total_length_next - 16'(header_bytes)) == payload_count_next);

    pay_res                          = '0;
    pay_res.kind                     = KIND_PAYLOAD;
    pay_res.payload_byte             = data_byte;
    pay_res.matched_port             = match_port_next;
    pay_res.matched_from_destination = match_direction_next;

    verd_res                          = '0;
    verd_res.kind                     = KIND_VERDICT;
    verd_res.verdict                  = frame_ok;
    verd_res.matched_port             = match_found_next ? match_port_next : 16'd0;
    verd_res.matched_from_destination = match_found_next & match_direction_next;
    verd_res.payload_length           = payload_count_next;
    verd_res.last_result              = 1'b1;

    push.count  = in_fire ? (2'(emit_payload) + 2'(last_byte)) : 2'd0;
    push.first  = emit_payload ? pay_res : verd_res;
    push.second = verd_res;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && last_byte)) begin
      byte_position    <= '0;
      ip_header_words  <= '0;
      tcp_header_words <= '0;
      ip_total_length  <= '0;
      source_port      <= '0;
      destination_port <= '0;
      match_found      <= 1'b0;
      match_port       <= '0;
      match_direction  <= 1'b0;
      payload_count    <= '0;
      count_overflow   <= 1'b0;
    end else if (in_fire) begin
      byte_position    <= byte_position_next;
      ip_header_words  <= ip_header_words_next;
      tcp_header_words <= tcp_header_words_next;
      ip_total_length  <= ip_total_length_next;
      source_port      <= source_port_next;
      destination_port <= destination_port_next;
      match_found      <= match_found_next;
      match_port       <= match_port_next;
      match_direction  <= match_direction_next;
      payload_count    <= payload_count_next;
      count_overflow   <= count_overflow_next;
    end
  end

  // Payload is only counted once a legal data offset has been seen.
  a_payload_needs_offset: assert property (@(posedge clk) disable iff (rst)
    payload_count != 16'd0 |-> tcp_header_words >= 4'(MIN_TCP_WORDS))
    else $error("payload counted without a valid TCP data offset");

  // The final byte of a frame always restarts the parse.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> byte_position == 16'd0 && !match_found)
    else $error("frame state not cleared after the final byte");

  // A recorded match always names one of the frame's own ports.
  a_match_is_frame_port: assert property (@(posedge clk) disable iff (rst)
    match_found |-> match_port == (match_direction ? destination_port : source_port))
    else $error("recorded match disagrees with the frame ports");

endmodule

// ----- src/tpfpe_result_queue.sv -----
module tpfpe_result_queue
  import tpfpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  localparam int PTR_W = $clog2(RESULT_DEPTH);
  localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

  result_t            slots [RESULT_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign out_valid  = (count != '0);
  assign out_result = slots[rptr];
  assign pop        = out_valid && out_ready;
  // Two free slots cover the worst case of a payload byte plus its verdict.
  assign room       = (count <= CNT_W'(RESULT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.count);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RESULT_DEPTH))
    else $error("result queue overfilled");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= CNT_W'(RESULT_DEPTH - 2))
    else $error("results pushed without two free slots");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> count == $past(count) - CNT_W'(1))
    else $error("queue count wrong after a lone pop");

endmodule

// ----- src/tcp_port_filter_payload_extract_core.sv -----
// Channel  | Direction | Word contents
// ---------+-----------+------------------------------------------------------------
// s_axis   | in        | one frame byte; tlast marks the final byte of the frame
// m_axis   | out       | payload byte (tuser 0) or frame verdict (tuser 1, tlast 1)
// cfg      | in        | register write: index and data, always ready
//
// A byte is taken every cycle while the result queue has two free slots; the parse,
// the port compare and the verdict are one combinational pass from the frame state
// into the queue, so with an empty queue a result is visible on m_axis in the cycle
// after its byte. A stalled m_axis backs words up in the four-entry result queue,
// and s_axis_tready drops while three or more words wait; a final byte of a matched
// payload yields two words. Reset is synchronous and clears frame state, registers
// and the queue.
module tcp_port_filter_payload_extract_core
  import tpfpe_pkg::*;
#(
  parameter int PORT_ENTRIES = PORT_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Frame bytes in. tdata: data_byte[7:0].
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,
  input  logic                   s_axis_tlast,
  // Results out. tdata: payload_byte[7:0], verdict[8], matched_port[24:9],
  // matched_from_destination[25], payload_length[41:26], zero[47:42].
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  // tuser: kind[0], zero for a payload byte and one for a verdict.
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  push_t   push;
  result_t res;
  logic    room;
  logic    in_fire;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = room;
  assign in_fire       = s_axis_tvalid && room;

  // Register file. Writes to an undefined index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT: cfg.entry_count <= cfg_data[2:0];
        REG_PORT_0:      cfg.ports[0]    <= cfg_data;
        REG_PORT_1:      cfg.ports[1]    <= cfg_data;
        REG_PORT_2:      cfg.ports[2]    <= cfg_data;
        REG_PORT_3:      cfg.ports[3]    <= cfg_data;
        REG_DIR_MASK:    cfg.dir_mask    <= cfg_data[PORT_REGS-1:0];
        default:         ;
      endcase
    end
  end

  tpfpe_parser #(
    .PORT_ENTRIES(PORT_ENTRIES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_fire  (in_fire),
    .data_byte(s_axis_tdata),
    .last_byte(s_axis_tlast),
    .push     (push)
  );

  tpfpe_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_result(res)
  );

  assign m_axis_tdata = {6'd0, res.payload_length, res.matched_from_destination,
                         res.matched_port, res.verdict, res.payload_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last_result;

endmodule
